// ----- hdl/sync_id_length_frame_parser_defines.svh -----
// assertion macros for the frame parser
// used by the top level; no other dependencies
`ifndef SYNC_ID_LENGTH_FRAME_PARSER_DEFINES_SVH
`define SYNC_ID_LENGTH_FRAME_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on clk outside reset
`define SIDLFP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame parser check failed");
// next-cycle implication, checked on clk outside reset
`define SIDLFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame parser check failed");
`else
`define SIDLFP_ASSERT_NOW(lbl, ante, cons)
`define SIDLFP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/sidlfp_pkg.sv -----
// shared types, widths and codes for the frame parser
// no dependencies
`timescale 1ns / 1ps

package sidlfp_pkg;

	// buffer size and field widths
	localparam int MAX_PAYLOAD = 64;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 7;
	localparam int POS_W       = 6;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 2'd1;

	// register reset values
	localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'hAA;
	localparam logic [LEN_W-1:0]  LIMIT_RESET = 7'd64;

	// controller states
	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_HUNT = 3'd0;
	localparam logic [ST_W-1:0] ST_ID   = 3'd1;
	localparam logic [ST_W-1:0] ST_LEN  = 3'd2;
	localparam logic [ST_W-1:0] ST_DATA = 3'd3;
	localparam logic [ST_W-1:0] ST_RD   = 3'd4;
	localparam logic [ST_W-1:0] ST_EMIT = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic take_id;
		logic take_len;
		logic write_byte;
		logic rd_clear;
		logic issue_read;
		logic load_empty;
		logic load_byte;
	} sidlfp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic sync_match;
		logic len_over;
		logic len_zero;
		logic fill_done;
		logic rd_last;
		logic out_free;
	} sidlfp_sts_t;

endpackage

// ----- hdl/sidlfp_ctrl.sv -----
// controller state machine for the frame parser
// depends on sidlfp_pkg
`timescale 1ns / 1ps

module sidlfp_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  sidlfp_pkg::sidlfp_sts_t        sts,
	output sidlfp_pkg::sidlfp_cmd_t        cmd,
	output logic [sidlfp_pkg::ST_W-1:0]    state
);

	logic [sidlfp_pkg::ST_W-1:0] state_q;
	logic [sidlfp_pkg::ST_W-1:0] state_d;
	logic                        in_acc;

	assign state  = state_q;
	assign in_acc = in_valid & in_ready;

	// ready per state; the length byte may need the output slot
	always_comb begin
		unique case (state_q)
			sidlfp_pkg::ST_HUNT,
			sidlfp_pkg::ST_ID,
			sidlfp_pkg::ST_DATA: in_ready = 1'b1;
			sidlfp_pkg::ST_LEN:  in_ready = sts.out_free;
			default:             in_ready = 1'b0;
		endcase
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			sidlfp_pkg::ST_HUNT: begin
				if (in_acc && sts.sync_match) state_d = sidlfp_pkg::ST_ID;
			end
			sidlfp_pkg::ST_ID: begin
				if (in_acc) begin
					cmd.take_id = 1'b1;
					state_d     = sidlfp_pkg::ST_LEN;
				end
			end
			sidlfp_pkg::ST_LEN: begin
				if (in_acc) begin
					if (sts.len_over) begin
						state_d = sidlfp_pkg::ST_HUNT;
					end else if (sts.len_zero) begin
						cmd.load_empty = 1'b1;
						state_d        = sidlfp_pkg::ST_HUNT;
					end else begin
						cmd.take_len = 1'b1;
						state_d      = sidlfp_pkg::ST_DATA;
					end
				end
			end
			sidlfp_pkg::ST_DATA: begin
				if (in_acc) begin
					cmd.write_byte = 1'b1;
					if (sts.fill_done) begin
						cmd.rd_clear = 1'b1;
						state_d      = sidlfp_pkg::ST_RD;
					end
				end
			end
			sidlfp_pkg::ST_RD: begin
				cmd.issue_read = 1'b1;
				state_d        = sidlfp_pkg::ST_EMIT;
			end
			sidlfp_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_byte = 1'b1;
					state_d       = sts.rd_last ? sidlfp_pkg::ST_HUNT : sidlfp_pkg::ST_RD;
				end
			end
			default: state_d = sidlfp_pkg::ST_HUNT;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidlfp_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/sidlfp_dp.sv -----
// datapath for the frame parser: config registers, header hold,
// payload buffer, counters and output register; depends on sidlfp_pkg
`timescale 1ns / 1ps

module sidlfp_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sidlfp_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                                cfg_valid,
	input  logic [sidlfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sidlfp_pkg::BYTE_W-1:0]       cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [sidlfp_pkg::BYTE_W-1:0]       frame_id,
	output logic [sidlfp_pkg::LEN_W-1:0]        frame_length,
	output logic [sidlfp_pkg::BYTE_W-1:0]       data_byte,
	output logic [sidlfp_pkg::POS_W-1:0]        byte_position,
	output logic                                run_last,
	output logic                                empty_frame,
	input  sidlfp_pkg::sidlfp_cmd_t             cmd,
	output sidlfp_pkg::sidlfp_sts_t             sts
);

	localparam logic [sidlfp_pkg::LEN_W-1:0] MAX_LEN =
		sidlfp_pkg::LEN_W'(sidlfp_pkg::MAX_PAYLOAD);

	logic [sidlfp_pkg::BYTE_W-1:0] sync_value_q;
	logic [sidlfp_pkg::LEN_W-1:0]  length_limit_q;
	logic [sidlfp_pkg::BYTE_W-1:0] held_id_q;
	logic [sidlfp_pkg::LEN_W-1:0]  held_length_q;
	logic [sidlfp_pkg::LEN_W-1:0]  fill_count_q;
	logic [sidlfp_pkg::LEN_W-1:0]  rd_ptr_q;
	logic [sidlfp_pkg::BYTE_W-1:0] rd_data_q;
	logic [sidlfp_pkg::BYTE_W-1:0] payload_mem_q [sidlfp_pkg::MAX_PAYLOAD];
	logic                          out_valid_q;
	logic [sidlfp_pkg::BYTE_W-1:0] frame_id_q;
	logic [sidlfp_pkg::LEN_W-1:0]  frame_length_q;
	logic [sidlfp_pkg::BYTE_W-1:0] data_byte_q;
	logic [sidlfp_pkg::POS_W-1:0]  byte_position_q;
	logic                          run_last_q;
	logic                          empty_frame_q;
	logic [sidlfp_pkg::LEN_W-1:0]  limit;
	logic [sidlfp_pkg::LEN_W-1:0]  fill_next;
	logic [sidlfp_pkg::LEN_W-1:0]  rd_next;

	// limit in force saturates at the buffer size
	assign limit     = (length_limit_q > MAX_LEN) ? MAX_LEN : length_limit_q;
	assign fill_next = fill_count_q + 1'b1;
	assign rd_next   = rd_ptr_q + 1'b1;

	// status toward the controller
	assign sts.sync_match = (rx_byte == sync_value_q);
	assign sts.len_over   = (rx_byte > {1'b0, limit});
	assign sts.len_zero   = (rx_byte == '0);
	assign sts.fill_done  = (fill_next == held_length_q);
	assign sts.rd_last    = (rd_next == held_length_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q   <= sidlfp_pkg::SYNC_RESET;
			length_limit_q <= sidlfp_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sidlfp_pkg::REG_SYNC_VALUE:   sync_value_q   <= cfg_data;
				sidlfp_pkg::REG_LENGTH_LIMIT: length_limit_q <= cfg_data[sidlfp_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// frame header hold and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_id_q     <= '0;
			held_length_q <= '0;
			fill_count_q  <= '0;
			rd_ptr_q      <= '0;
		end else begin
			if (cmd.take_id) held_id_q <= rx_byte;
			if (cmd.take_len) begin
				held_length_q <= rx_byte[sidlfp_pkg::LEN_W-1:0];
				fill_count_q  <= '0;
			end else if (cmd.write_byte) begin
				fill_count_q  <= fill_next;
			end
			if (cmd.rd_clear) begin
				rd_ptr_q <= '0;
			end else if (cmd.load_byte) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	// payload buffer with registered read
	always_ff @(posedge clk) begin
		if (cmd.write_byte) payload_mem_q[fill_count_q[sidlfp_pkg::POS_W-1:0]] <= rx_byte;
		if (cmd.issue_read) rd_data_q <= payload_mem_q[rd_ptr_q[sidlfp_pkg::POS_W-1:0]];
	end

	// output request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_empty || cmd.load_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output request payload
	always_ff @(posedge clk) begin
		if (cmd.load_empty) begin
			frame_id_q      <= held_id_q;
			frame_length_q  <= '0;
			data_byte_q     <= '0;
			byte_position_q <= '0;
			run_last_q      <= 1'b1;
			empty_frame_q   <= 1'b1;
		end else if (cmd.load_byte) begin
			frame_id_q      <= held_id_q;
			frame_length_q  <= held_length_q;
			data_byte_q     <= rd_data_q;
			byte_position_q <= rd_ptr_q[sidlfp_pkg::POS_W-1:0];
			run_last_q      <= sts.rd_last;
			empty_frame_q   <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_id      = frame_id_q;
	assign frame_length  = frame_length_q;
	assign data_byte     = data_byte_q;
	assign byte_position = byte_position_q;
	assign run_last      = run_last_q;
	assign empty_frame   = empty_frame_q;

endmodule

// ----- hdl/sync_id_length_frame_parser.sv -----
// sync/id/length frame parser top: controller plus datapath; uses sidlfp_pkg.
// header and payload bytes are taken one per cycle, the length byte only while the
// output slot is free; an empty frame's request is out in the cycle after its length
// byte. after the last payload byte, each request of the run takes a buffer read (ST_RD,
// registered read port) then a load (ST_EMIT, waits for a free output slot); input is
// held off during the run. reset clears control, sync to 0xAA, limit to 64; the payload buffer is not cleared.
`timescale 1ns / 1ps
`include "sync_id_length_frame_parser_defines.svh"

module sync_id_length_frame_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sidlfp_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sidlfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sidlfp_pkg::BYTE_W-1:0]       cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sidlfp_pkg::BYTE_W-1:0]       frame_id,
	output logic [sidlfp_pkg::LEN_W-1:0]        frame_length,
	output logic [sidlfp_pkg::BYTE_W-1:0]       data_byte,
	output logic [sidlfp_pkg::POS_W-1:0]        byte_position,
	output logic                                run_last,
	output logic                                empty_frame
);

	sidlfp_pkg::sidlfp_cmd_t     cmd;
	sidlfp_pkg::sidlfp_sts_t     sts;
	logic [sidlfp_pkg::ST_W-1:0] state;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	// controller
	sidlfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	// datapath
	sidlfp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.frame_id      (frame_id),
		.frame_length  (frame_length),
		.data_byte     (data_byte),
		.byte_position (byte_position),
		.run_last      (run_last),
		.empty_frame   (empty_frame),
		.cmd           (cmd),
		.sts           (sts)
	);

	// checks
	`SIDLFP_ASSERT_NOW(a_no_input_in_run, (state == sidlfp_pkg::ST_RD) || (state == sidlfp_pkg::ST_EMIT), !in_ready)
	`SIDLFP_ASSERT_NOW(a_last_pos, out_valid && run_last && !empty_frame, ({1'b0, byte_position} + 7'd1) == frame_length)
	`SIDLFP_ASSERT_NOW(a_empty_shape, out_valid && empty_frame, run_last && (frame_length == '0) && (data_byte == '0))
	`SIDLFP_ASSERT_NEXT(a_load_shows, cmd.load_byte || cmd.load_empty, out_valid)

endmodule
